### design/stre_pkg.sv
// Package for the sparse-table range extreme block.
// Holds the size defaults, the port widths and the compare and encode helpers.
// No dependencies.
`timescale 1ns / 1ps

package stre_pkg;

  localparam int MAX_ELEMS = 1024;
  localparam int LEVELS    = 11;

  localparam int DATA_W    = 64;
  localparam int POS_W     = 11;
  localparam int POS_LOG_W = $clog2(POS_W);

  // Signed extreme of two words: the larger one when want_max is set.
  function automatic logic [DATA_W-1:0] pick(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b,
                                             input logic              want_max);
    logic a_greater;
    a_greater = $signed(a) > $signed(b);
    if (want_max) begin
      pick = a_greater ? a : b;
    end else begin
      pick = a_greater ? b : a;
    end
  endfunction

  // Priority encoder: index of the highest set bit, zero for a zero input.
  function automatic logic [POS_LOG_W-1:0] floor_log2(input logic [POS_W-1:0] x);
    floor_log2 = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (x[i]) begin
        floor_log2 = POS_LOG_W'(i);
      end
    end
  endfunction

endpackage

### design/stre_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
`timescale 1ns / 1ps

module stre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/sparse_table_range_extreme.sv
// Top level of the sparse-table range extreme block.
// Depends on stre_pkg and on stre_ram for the level table.
`timescale 1ns / 1ps

// Static range minimum or maximum query over up to MAX_ELEMS signed 64-bit
// values. A request is taken when start_i is high and busy_o is low. A load
// request (mode_i = 0) stores value_i at the next position and, without last_i,
// leaves busy_o low; a load that comes after a finished build starts a
// new array, and a load past capacity is dropped. A load with last_i set
// starts the build of the power-of-two levels when two or more elements are
// held, which keeps busy_o high while every table entry is made from two
// reads of the single read port of the table RAM and one write. The
// min/max selection bit is sampled when a build starts, and queries use the
// mode the table was built with. A query request (mode_i = 1) over a valid
// range holds busy_o through two table reads and one compare (ST_QRDA,
// ST_QRDB, ST_QOUT), and its result appears on result_o and status_o with
// valid_o high, registered from ST_QOUT. A query while no table is built,
// or with left_i = 0, left_i > right_i or right_i beyond the loaded count,
// answers in the next cycle with status_o = 1 and result_o = 0. Each result
// is shown for exactly one cycle; the receiver cannot stall the block, so it
// must take the result whenever valid_o is high. No clearing pass runs after
// reset: a table entry is read only after the build that writes it.
module sparse_table_range_extreme #(
  parameter int MAX_ELEMS = stre_pkg::MAX_ELEMS,
  parameter int LEVELS    = stre_pkg::LEVELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              mode_i,
  input  logic signed [stre_pkg::DATA_W-1:0] value_i,
  input  logic                              last_i,
  input  logic [stre_pkg::POS_W-1:0]        left_i,
  input  logic [stre_pkg::POS_W-1:0]        right_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  output logic                              valid_o,
  output logic signed [stre_pkg::DATA_W-1:0] result_o,
  output logic                              status_o
);

  localparam int DW     = stre_pkg::DATA_W;
  localparam int PW     = stre_pkg::POS_W;
  localparam int IW     = $clog2(MAX_ELEMS);
  localparam int CW     = $clog2(MAX_ELEMS + 1);
  localparam int LW     = $clog2(LEVELS);
  localparam int SW     = ((CW > LEVELS) ? CW : LEVELS) + 1;
  localparam int AW     = (CW > PW) ? CW : PW;
  localparam int DEPTH  = LEVELS * (2 ** IW);
  localparam int RAW    = LW + IW;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_BRDA = 7'b0000010,
    ST_BRDB = 7'b0000100,
    ST_BWR  = 7'b0001000,
    ST_QRDA = 7'b0010000,
    ST_QRDB = 7'b0100000,
    ST_QOUT = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              ready_q, ready_d;
  logic              max_mode_q;
  logic              built_max_q, built_max_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [PW-1:0]     right_q, right_d;
  logic [DW-1:0]     a_q, a_d;
  logic              valid_q, valid_d;
  logic [DW-1:0]     result_q, result_d;
  logic              status_q, status_d;

  logic              ram_we;
  logic [RAW-1:0]    ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic [RAW-1:0]    ram_raddr;
  logic [DW-1:0]     ram_rdata;

  // Build and query address arithmetic.
  logic [CW-1:0]     count_eff;
  logic [SW-1:0]     pow_k;
  logic [SW-1:0]     pow_next;
  logic [SW-1:0]     half_k;
  logic [SW-1:0]     idx_b_sum;
  logic [LW:0]       lvl_next;
  logic              level_end;
  logic [AW-1:0]     left_m1;
  logic [AW-1:0]     right_b;
  logic [PW-1:0]     q_len;
  logic [stre_pkg::POS_LOG_W-1:0] q_log;
  logic              q_bad;
  logic              accept;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign count_eff = ready_q ? '0 : count_q;

  assign pow_k     = SW'(1) << lvl_q;
  assign lvl_next  = {1'b0, lvl_q} + (LW + 1)'(1);
  assign pow_next  = SW'(1) << lvl_next;
  assign half_k    = SW'(1) << (lvl_q - LW'(1));
  assign idx_b_sum = SW'(idx_q) + half_k;
  assign level_end = (SW'(idx_q) + pow_k) == SW'(count_q);

  assign left_m1   = AW'(left_i) - AW'(1);
  assign right_b   = AW'(right_q) - (AW'(1) << lvl_q);
  assign q_len     = right_i - left_i + PW'(1);
  assign q_log     = stre_pkg::floor_log2(q_len);
  assign q_bad     = !ready_q || (left_i == '0) || (left_i > right_i) ||
                     (AW'(right_i) > AW'(count_q));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ready_d     = ready_q;
    built_max_d = built_max_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    right_d     = right_q;
    a_d         = a_q;
    valid_d     = 1'b0;
    result_d    = result_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = {LW'(0), count_eff[IW-1:0]};
    ram_wdata   = value_i;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept && !mode_i) begin
          // Load: a load after a finished build starts over at position one.
          ready_d = 1'b0;
          count_d = count_eff;
          if (SW'(count_eff) < SW'(MAX_ELEMS)) begin
            ram_we  = 1'b1;
            count_d = count_eff + CW'(1);
          end
          if (last_i) begin
            built_max_d = max_mode_q;
            if (SW'(count_d) >= SW'(2)) begin
              lvl_d   = LW'(1);
              idx_d   = '0;
              state_d = ST_BRDA;
            end else begin
              ready_d = 1'b1;
            end
          end
        end else if (accept) begin
          if (q_bad) begin
            valid_d  = 1'b1;
            result_d = '0;
            status_d = 1'b1;
          end else begin
            if (int'(q_log) > LEVELS - 1) begin
              lvl_d = LW'(LEVELS - 1);
            end else begin
              lvl_d = LW'(q_log);
            end
            idx_d   = left_m1[IW-1:0];
            right_d = right_i;
            state_d = ST_QRDA;
          end
        end
      end
      ST_BRDA: begin
        ram_raddr = {lvl_q - LW'(1), idx_q};
        state_d   = ST_BRDB;
      end
      ST_BRDB: begin
        ram_raddr = {lvl_q - LW'(1), idx_b_sum[IW-1:0]};
        a_d       = ram_rdata;
        state_d   = ST_BWR;
      end
      ST_BWR: begin
        ram_we    = 1'b1;
        ram_waddr = {lvl_q, idx_q};
        ram_wdata = stre_pkg::pick(a_q, ram_rdata, built_max_q);
        if (level_end) begin
          if ((int'(lvl_next) < LEVELS) && (pow_next <= SW'(count_q))) begin
            lvl_d   = lvl_next[LW-1:0];
            idx_d   = '0;
            state_d = ST_BRDA;
          end else begin
            ready_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_BRDA;
        end
      end
      ST_QRDA: begin
        ram_raddr = {lvl_q, idx_q};
        state_d   = ST_QRDB;
      end
      ST_QRDB: begin
        ram_raddr = {lvl_q, right_b[IW-1:0]};
        a_d       = ram_rdata;
        state_d   = ST_QOUT;
      end
      ST_QOUT: begin
        valid_d  = 1'b1;
        result_d = stre_pkg::pick(a_q, ram_rdata, built_max_q);
        status_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ready_q     <= 1'b0;
      max_mode_q  <= 1'b1;
      built_max_q <= 1'b1;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ready_q     <= ready_d;
      built_max_q <= built_max_d;
      valid_q     <= valid_d;
      if (cfg_we_i) begin
        max_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    idx_q    <= idx_d;
    right_q  <= right_d;
    a_q      <= a_d;
    result_q <= result_d;
    status_q <= status_d;
  end

  stre_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign status_o = status_q;

endmodule

### design/stre_checker.sv
// Port-level checker for the sparse-table range extreme block and its bind.
// Depends on stre_pkg for the port widths.
`timescale 1ns / 1ps

module stre_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        mode_i,
  input logic [stre_pkg::POS_W-1:0]  left_i,
  input logic                        valid_o,
  input logic [stre_pkg::DATA_W-1:0] result_o,
  input logic                        status_o
);

  logic req;
  assign req = start_i && !busy_o;

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (result_o == '0))
    else $error("error result with nonzero value");

  // A query with a zero left bound is refused in the next cycle.
  a_left_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && mode_i && (left_i == '0)) |=> (valid_o && status_o))
    else $error("zero left bound not reported as an error");

  // A load request never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && !mode_i) |=> !valid_o)
    else $error("result after a load request");

  // A query request either answers at once or keeps the block busy.
  a_query_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && mode_i) |=> (valid_o || busy_o))
    else $error("query request dropped");

endmodule

bind sparse_table_range_extreme stre_checker u_stre_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .mode_i  (mode_i),
  .left_i  (left_i),
  .valid_o (valid_o),
  .result_o(result_o),
  .status_o(status_o)
);

### dv/stre_range_checker.sv
`timescale 1ns / 1ps
// Checker for the sparse-table range extreme block: watches requests, register
// writes and answers, predicts every answer and compares it field by field.
// Depends on stre_pkg for the sizes and the port widths.

module stre_range_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        mode_i,
  input  logic [stre_pkg::DATA_W-1:0] value_i,
  input  logic                        last_i,
  input  logic [stre_pkg::POS_W-1:0]  left_i,
  input  logic [stre_pkg::POS_W-1:0]  right_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        valid_i,
  input  logic [stre_pkg::DATA_W-1:0] result_i,
  input  logic                        status_i,
  output int                          fails_o,
  output int                          pending_o,
  output int                          checked_o
);
  import stre_pkg::*;

  localparam logic REQ_QUERY  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              status;
  } answer_t;

  // Own copy of the level table and of the control state.
  logic [DATA_W-1:0] levels_q [LEVELS][MAX_ELEMS];
  int unsigned       elem_count;
  logic              table_built;
  logic              max_sel;
  logic              built_max_sel;
  answer_t           expected_q [$];

  function automatic logic [DATA_W-1:0] extreme2(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic              want_max);
    logic a_wins;
    if (want_max) begin
      a_wins = $signed(a) > $signed(b);
    end else begin
      a_wins = $signed(a) < $signed(b);
    end
    return a_wins ? a : b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t     want;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned k;
    int unsigned half;
    if (!rst_ni) begin
      elem_count    = 0;
      table_built   = 1'b0;
      max_sel       = 1'b1;
      built_max_sel = 1'b1;
      expected_q.delete();
      fails_o       = 0;
      pending_o     = 0;
      checked_o     = 0;
    end else begin
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected answer: result %h status %0b", result_i, status_i);
          fails_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (result_i !== want.result) begin
            $error("result: expected %h, actual %h", want.result, result_i);
            fails_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, status_i);
            fails_o++;
          end
        end
      end

      if (start_i && !busy_i) begin
        if (mode_i == REQ_QUERY) begin
          want.result = '0;
          want.status = STATUS_BAD;
          lo = left_i;
          hi = right_i;
          if (table_built && lo != 0 && lo <= hi && hi <= elem_count) begin
            span = hi - lo + 1;
            k = 0;
            for (int b = 0; b <= POS_W; b++) begin
              if (span[b]) k = b;
            end
            if (k > LEVELS - 1) k = LEVELS - 1;
            want.result = extreme2(levels_q[k][lo-1], levels_q[k][hi-(1<<k)],
                                   built_max_sel);
            want.status = STATUS_OK;
          end
          expected_q.push_back(want);
        end else begin
          // A load after a finished build starts a new array.
          if (table_built) begin
            elem_count  = 0;
            table_built = 1'b0;
          end
          if (elem_count < MAX_ELEMS) begin
            levels_q[0][elem_count] = value_i;
            elem_count++;
          end
          if (last_i) begin
            built_max_sel = max_sel;
            for (int lv = 1; lv < LEVELS && (1 << lv) <= elem_count; lv++) begin
              half = 1 << (lv - 1);
              for (int i = 0; i + (1 << lv) <= elem_count; i++) begin
                levels_q[lv][i] = extreme2(levels_q[lv-1][i], levels_q[lv-1][i+half],
                                           built_max_sel);
              end
            end
            table_built = 1'b1;
          end
        end
      end

      if (cfg_we_i) max_sel = cfg_wdata_i;
      pending_o = expected_q.size();
    end
  end

endmodule

### dv/sparse_table_range_extreme_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the sparse-table range extreme block: clock, reset,
// request and register stimulus, watchdog and verdict.
// Depends on stre_pkg, the block itself and the stre_range_checker module.

module sparse_table_range_extreme_tb;
  import stre_pkg::*;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [DATA_W-1:0] MIN64 = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX64 = {1'b0, {(DATA_W-1){1'b1}}};

  // Requests to send in total, directed part included.
  localparam int TOTAL_ITEMS = 1925;
  // The longest correct silence is the build of a full array.
  localparam int IDLE_LIMIT  = 120000;
  // Extra idle cycles to wait after the last answer.
  localparam int TAIL_CYCLES = 16;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              mode_i;
  logic [DATA_W-1:0] value_i;
  logic              last_i;
  logic [POS_W-1:0]  left_i;
  logic [POS_W-1:0]  right_i;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              valid_o;
  logic [DATA_W-1:0] result_o;
  logic              status_o;

  int fails;
  int pending;
  int checked;

  // Stimulus bookkeeping. The shadow count only steers the choice of ranges.
  int unsigned shadow_count;
  bit          shadow_built;
  bit          idle_burst;
  logic        max_now;
  int          sent;
  int          loads_sent;
  int          queries_sent;
  int          builds_max;
  int          builds_min;
  int unsigned biggest;
  int          idle_cycles;

  sparse_table_range_extreme dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .last_i     (last_i),
    .left_i     (left_i),
    .right_i    (right_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .result_o   (result_o),
    .status_o   (status_o)
  );

  stre_range_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .last_i     (last_i),
    .left_i     (left_i),
    .right_i    (right_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_i    (valid_o),
    .result_i   (result_o),
    .status_i   (status_o),
    .fails_o    (fails),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The watchdog restarts whenever a request or an answer is taken.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without any transfer", idle_cycles);
      $display("** sparse_table_range_extreme: FAILED **");
      $finish;
    end
  end

  // Element values: mostly random words, with the signed extremes and small
  // values near zero mixed in so that ties and sign boundaries come up often.
  function automatic logic [DATA_W-1:0] draw_value();
    logic signed [DATA_W-1:0] near_zero;
    near_zero = DATA_W'($urandom_range(0, 16));
    near_zero = near_zero - 8;
    case ($urandom_range(0, 9))
      0:       return MIN64;
      1:       return MAX64;
      2, 3:    return near_zero;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Presents one request at a falling edge and holds it until the block takes
  // it. The task is entered and left at a falling edge; a request that follows
  // without a gap keeps start_i high, so start_i is never lowered and raised in
  // the same step.
  task automatic send_request(input logic             kind,
                              input logic [DATA_W-1:0] v,
                              input logic             fin,
                              input logic [POS_W-1:0]  lo,
                              input logic [POS_W-1:0]  hi);
    int gap;
    gap = idle_burst ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    mode_i  <= kind;
    value_i <= v;
    last_i  <= fin;
    left_i  <= lo;
    right_i <= hi;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    sent++;
  endtask

  // A load request; the range fields are ignored by the block and get noise.
  task automatic send_load(input logic [DATA_W-1:0] v, input logic fin);
    send_request(REQ_LOAD, v, fin, POS_W'($urandom_range(0, 2047)),
                 POS_W'($urandom_range(0, 2047)));
    loads_sent++;
    if (shadow_built) begin
      shadow_count = 0;
      shadow_built = 1'b0;
    end
    if (shadow_count < MAX_ELEMS) shadow_count++;
    if (fin) begin
      shadow_built = 1'b1;
      if (shadow_count > biggest) biggest = shadow_count;
      if (max_now) begin
        builds_max++;
      end else begin
        builds_min++;
      end
    end
  endtask

  // A query request; value and last are ignored by the block and get noise.
  task automatic send_query(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
    send_request(REQ_QUERY, {$urandom, $urandom}, 1'($urandom_range(0, 1)), lo, hi);
    queries_sent++;
  endtask

  // Mostly valid ranges over the current table (full span, power-of-two
  // lengths, single positions, arbitrary spans); the rest are broken ranges.
  task automatic send_random_query();
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    n = shadow_count;
    if (shadow_built && n > 0 && $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 4))
        0: begin
          lo = 1;
          hi = n;
        end
        1: begin
          span = 1 << $urandom_range(0, 10);
          if (span > n) span = n;
          lo = $urandom_range(1, n - span + 1);
          hi = lo + span - 1;
        end
        2: begin
          lo = $urandom_range(1, n);
          hi = lo;
        end
        default: begin
          lo = $urandom_range(1, n);
          hi = $urandom_range(lo, n);
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          lo = 0;
          hi = $urandom_range(0, 2047);
        end
        1: begin
          hi = $urandom_range(0, 2046);
          lo = $urandom_range(hi + 1, 2047);
        end
        2: begin
          hi = $urandom_range(n + 1, 2047);
          lo = $urandom_range(1, hi);
        end
        default: begin
          lo = $urandom_range(0, 2047);
          hi = $urandom_range(0, 2047);
        end
      endcase
    end
    send_query(POS_W'(lo), POS_W'(hi));
  endtask

  // Stops sending and waits until every answer is in and the block is idle.
  task automatic quiesce();
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // The mode register is only written while the block is idle.
  task automatic write_mode(input logic m);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    max_now     = m;
  endtask

  initial begin
    int          phase;
    int unsigned n;
    bit          noisy;
    bit          broken;

    start_i      = 1'b0;
    mode_i       = REQ_LOAD;
    value_i      = '0;
    last_i       = 1'b0;
    left_i       = '0;
    right_i      = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    rst_ni       = 1'b0;
    shadow_count = 0;
    shadow_built = 1'b0;
    idle_burst   = 1'b0;
    max_now      = 1'b1;
    sent         = 0;
    loads_sent   = 0;
    queries_sent = 0;
    builds_max   = 0;
    builds_min   = 0;
    biggest      = 0;
    idle_cycles  = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Queries before any table exists must be refused.
    send_query(11'd1, 11'd1);
    send_query(11'd0, 11'd0);
    // Five elements spanning both signed extremes, built in the reset max mode.
    send_load(MIN64, 1'b0);
    send_load(MAX64, 1'b0);
    send_load('0, 1'b0);
    send_load('1, 1'b0);
    send_load(64'd5, 1'b1);
    send_query(11'd1, 11'd5);
    send_query(11'd1, 11'd2);
    send_query(11'd2, 11'd2);
    send_query(11'd4, 11'd5);
    // Broken ranges: left past right, right past the count, left zero, and
    // positions with the top bit set.
    send_query(11'd3, 11'd2);
    send_query(11'd1, 11'd6);
    send_query(11'd0, 11'd3);
    send_query(11'd1024, 11'd1024);
    send_query(11'd2047, 11'd2047);
    // A load after a build starts over with a single element.
    send_load(64'd7, 1'b1);
    send_query(11'd1, 11'd1);
    send_query(11'd1, 11'd2);
    // While a new array is only partly loaded there is no table.
    send_load(MAX64, 1'b0);
    send_query(11'd1, 11'd1);
    send_load(MIN64, 1'b1);
    send_query(11'd1, 11'd2);

    // Random part: phases of one array each, followed by a burst of queries.
    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      phase++;
      if (phase == 1) begin
        write_mode(1'b0);
      end else if (phase == 2) begin
        write_mode(1'b1);
      end else if ($urandom_range(0, 3) == 0) begin
        write_mode(1'($urandom_range(0, 1)));
      end
      idle_burst = ($urandom_range(0, 3) != 0);

      noisy  = ($urandom_range(0, 4) == 0);
      broken = ($urandom_range(0, 9) == 0);
      if (phase == 4) begin
        // Fill to capacity and past it; the final, dropped load carries the
        // last mark and still builds the elements already held.
        n      = MAX_ELEMS + $urandom_range(1, 4);
        noisy  = 1'b0;
        broken = 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
        n = $urandom_range(64, 300);
      end else begin
        n = $urandom_range(1, 40);
      end

      // An array without a last mark leaves the table unbuilt; the next phase
      // keeps appending to it.
      for (int unsigned i = 0; i < n; i++) begin
        if (noisy && $urandom_range(0, 7) == 0) send_random_query();
        send_load(draw_value(), !broken && (i == n - 1));
      end

      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 24) == 0) quiesce();
        send_random_query();
      end
    end

    quiesce();
    $display("Run covered %0d requests: %0d loads and %0d queries, %0d answers checked.",
             sent, loads_sent, queries_sent, checked);
    $display("Tables built: %0d for maximum, %0d for minimum, largest array %0d.",
             builds_max, builds_min, biggest);
    if (fails == 0 && pending == 0) begin
      $display("** sparse_table_range_extreme: PASSED **");
    end else begin
      $display("** sparse_table_range_extreme: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
design/stre_pkg.sv
design/stre_ram.sv
design/sparse_table_range_extreme.sv
design/stre_checker.sv
dv/stre_range_checker.sv
dv/sparse_table_range_extreme_tb.sv
